// File: rtl/lspp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lspp_pkg
// Types and constants shared by the lidar scan packet parser modules.
// ----------------------------------------------------------------------------
package lspp_pkg;

    localparam logic [7:0] HDR_BYTE_A = 8'hAA;
    localparam logic [7:0] HDR_BYTE_B = 8'h55;

    // result kind codes
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_END    = 1'b1;

    // One received byte with its header classification.
    typedef struct packed {
        logic [7:0] data;
        logic       is_aa;
        logic       is_55;
    } byte_item_t;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage
`default_nettype wire

// File: rtl/lspp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lspp_front
// Accepts stream bytes and tags header bytes before they enter the queue.
// ----------------------------------------------------------------------------
module lspp_front (
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [7:0]              data_byte,
    input  wire lspp_pkg::queue_status_t q_status,
    output logic                         push,
    output lspp_pkg::byte_item_t         push_item
);
    import lspp_pkg::*;

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

    always_comb
    begin
        push_item.data  = data_byte;
        push_item.is_aa = (data_byte == HDR_BYTE_A);
        push_item.is_55 = (data_byte == HDR_BYTE_B);
    end

endmodule
`default_nettype wire

// File: rtl/lspp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lspp_queue
// Short FIFO of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
module lspp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire lspp_pkg::byte_item_t push_item,
    input  wire logic                 pop,
    output lspp_pkg::byte_item_t      head_item,
    output lspp_pkg::queue_status_t   q_status
);
    import lspp_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = PW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    byte_item_t    entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == DEPTH_C);
    assign q_status.empty = (count_reg == '0);
    assign head_item      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("queue count beyond depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// File: rtl/lspp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lspp_back
// Packet state machine: header capture, checksum, sample results.
// ----------------------------------------------------------------------------
module lspp_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire lspp_pkg::byte_item_t    head_item,
    input  wire lspp_pkg::queue_status_t q_status,
    output logic                         pop,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic                         kind,
    output logic [6:0]                   sample_index,
    output logic [13:0]                  distance_mm,
    output logic [14:0]                  start_angle,
    output logic [14:0]                  end_angle,
    output logic [7:0]                   packet_type,
    output logic                         last,
    output logic                         checksum_ok
);
    import lspp_pkg::*;

    localparam logic [3:0] PH_HUNT_A  = 4'd0;
    localparam logic [3:0] PH_HUNT_B  = 4'd1;
    localparam logic [3:0] PH_TYPE    = 4'd2;
    localparam logic [3:0] PH_COUNT   = 4'd3;
    localparam logic [3:0] PH_FSA_LO  = 4'd4;
    localparam logic [3:0] PH_FSA_HI  = 4'd5;
    localparam logic [3:0] PH_LSA_LO  = 4'd6;
    localparam logic [3:0] PH_LSA_HI  = 4'd7;
    localparam logic [3:0] PH_CS_0    = 4'd8;
    localparam logic [3:0] PH_CS_1    = 4'd9;
    localparam logic [3:0] PH_SAMPLES = 4'd10;

    localparam logic [15:0] HDR_WORD = {HDR_BYTE_A, HDR_BYTE_B};

    logic [3:0]  phase_reg, phase_next;
    logic        pair_hi_reg, pair_hi_next;
    logic [7:0]  left_reg, left_next;
    logic [15:0] ck_reg, ck_next;
    logic [7:0]  held_reg, held_next;
    logic [14:0] start_reg, start_next;
    logic [14:0] end_reg, end_next;
    logic [15:0] exp_reg, exp_next;
    logic [7:0]  type_reg, type_next;
    logic [6:0]  cnt_reg, cnt_next;

    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, kind_next;
    logic [6:0]  idx_reg, idx_next;
    logic [13:0] dist_reg, dist_next;
    logic        last_reg, last_next;
    logic        ok_reg, ok_next;
    logic        emit;

    logic [7:0]  b;

    assign b   = head_item.data;
    assign pop = !q_status.empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        phase_next   = phase_reg;
        pair_hi_next = pair_hi_reg;
        left_next    = left_reg;
        ck_next      = ck_reg;
        held_next    = held_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        exp_next     = exp_reg;
        type_next    = type_reg;
        cnt_next     = cnt_reg;
        emit         = 1'b0;
        kind_next    = kind_reg;
        idx_next     = idx_reg;
        dist_next    = dist_reg;
        last_next    = last_reg;
        ok_next      = ok_reg;

        case (phase_reg)
            PH_HUNT_B:
            begin
                if (head_item.is_55)
                begin
                    ck_next    = HDR_WORD;
                    phase_next = PH_TYPE;
                end
                else if (!head_item.is_aa)
                begin
                    phase_next = PH_HUNT_A;
                end
            end
            PH_TYPE:
            begin
                type_next  = b;
                phase_next = PH_COUNT;
            end
            PH_COUNT:
            begin
                left_next  = b;
                ck_next    = ck_reg ^ {type_reg, b};
                phase_next = PH_FSA_LO;
            end
            PH_FSA_LO:
            begin
                held_next  = b;
                phase_next = PH_FSA_HI;
            end
            PH_FSA_HI:
            begin
                ck_next    = ck_reg ^ {held_reg, b};
                start_next = {b, held_reg[7:1]};
                phase_next = PH_LSA_LO;
            end
            PH_LSA_LO:
            begin
                held_next  = b;
                phase_next = PH_LSA_HI;
            end
            PH_LSA_HI:
            begin
                ck_next    = ck_reg ^ {held_reg, b};
                end_next   = {b, held_reg[7:1]};
                phase_next = PH_CS_0;
            end
            PH_CS_0:
            begin
                held_next  = b;
                phase_next = PH_CS_1;
            end
            PH_CS_1:
            begin
                exp_next     = {held_reg, b};
                cnt_next     = '0;
                pair_hi_next = 1'b0;
                if (left_reg == '0)
                begin
                    // empty packet: end result on the checksum byte
                    emit       = 1'b1;
                    kind_next  = KIND_END;
                    idx_next   = '0;
                    dist_next  = '0;
                    last_next  = 1'b1;
                    ok_next    = (ck_reg == {held_reg, b});
                    phase_next = PH_HUNT_A;
                end
                else
                begin
                    phase_next = PH_SAMPLES;
                end
            end
            PH_SAMPLES:
            begin
                left_next = left_reg - 1'b1;
                if (!pair_hi_reg)
                begin
                    held_next = b;
                    if (left_reg == 8'd1)
                    begin
                        // odd trailing byte, paired with zero
                        ck_next    = ck_reg ^ {b, 8'h00};
                        emit       = 1'b1;
                        kind_next  = KIND_END;
                        idx_next   = cnt_reg;
                        dist_next  = '0;
                        last_next  = 1'b1;
                        ok_next    = ((ck_reg ^ {b, 8'h00}) == exp_reg);
                        phase_next = PH_HUNT_A;
                    end
                    else
                    begin
                        pair_hi_next = 1'b1;
                    end
                end
                else
                begin
                    ck_next      = ck_reg ^ {held_reg, b};
                    pair_hi_next = 1'b0;
                    emit         = 1'b1;
                    kind_next    = KIND_SAMPLE;
                    idx_next     = cnt_reg;
                    dist_next    = {b, held_reg[7:2]};
                    last_next    = (left_reg == 8'd1);
                    ok_next      = (left_reg == 8'd1)
                                   && ((ck_reg ^ {held_reg, b}) == exp_reg);
                    cnt_next     = cnt_reg + 1'b1;
                    if (left_reg == 8'd1)
                    begin
                        phase_next = PH_HUNT_A;
                    end
                end
            end
            default:
            begin
                phase_next = head_item.is_aa ? PH_HUNT_B : PH_HUNT_A;
            end
        endcase
    end

    always_comb
    begin
        if (pop && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT_A;
            pair_hi_reg   <= 1'b0;
            left_reg      <= '0;
            ck_reg        <= '0;
            held_reg      <= '0;
            start_reg     <= '0;
            end_reg       <= '0;
            exp_reg       <= '0;
            type_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg   <= phase_next;
                pair_hi_reg <= pair_hi_next;
                left_reg    <= left_next;
                ck_reg      <= ck_next;
                held_reg    <= held_next;
                start_reg   <= start_next;
                end_reg     <= end_next;
                exp_reg     <= exp_next;
                type_reg    <= type_next;
                cnt_reg     <= cnt_next;
            end
        end
    end

    // result payload, loaded only with a new result
    logic [14:0] o_start_reg;
    logic [14:0] o_end_reg;
    logic [7:0]  o_type_reg;

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            kind_reg    <= kind_next;
            idx_reg     <= idx_next;
            dist_reg    <= dist_next;
            last_reg    <= last_next;
            ok_reg      <= ok_next;
            o_start_reg <= start_reg;
            o_end_reg   <= end_reg;
            o_type_reg  <= type_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign sample_index = idx_reg;
    assign distance_mm  = dist_reg;
    assign start_angle  = o_start_reg;
    assign end_angle    = o_end_reg;
    assign packet_type  = o_type_reg;
    assign last         = last_reg;
    assign checksum_ok  = ok_reg;

`ifndef SYNTHESIS
    a_ok_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !last_reg |-> !ok_reg)
        else $error("checksum flag on a result that is not last");
    a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == KIND_END) |-> last_reg && dist_reg == '0)
        else $error("end result without last or with distance");
    a_hunt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        pop && emit && last_next |=> phase_reg == PH_HUNT_A)
        else $error("parser not hunting after packet end");
`endif

endmodule
`default_nettype wire

// File: rtl/lidar_scan_packet_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_scan_packet_parser_unit
// Byte-serial lidar scan packet parser with XOR checksum check.
// ----------------------------------------------------------------------------
// Channel  Handshake            Payload
// -------  -------------------  ------------------------------------------
// in       in_valid / in_stall  data_byte
// out      out_valid/out_stall  kind, sample_index, distance_mm,
//                               start_angle, end_angle, packet_type,
//                               last, checksum_ok
//
// One byte per cycle while neither side stalls; a result passes the queue register
// and then the output register of the back state machine.
// The front stalls only when the byte queue is full; the back stalls only
// when a result is held by out_stall.
// rst_n is asynchronous; reset empties the queue and puts the parser in
// header hunt.
// ----------------------------------------------------------------------------
module lidar_scan_packet_parser_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [6:0]       sample_index,
    output logic [13:0]      distance_mm,
    output logic [14:0]      start_angle,
    output logic [14:0]      end_angle,
    output logic [7:0]       packet_type,
    output logic             last,
    output logic             checksum_ok
);
    import lspp_pkg::*;

    queue_status_t q_status;
    byte_item_t    push_item;
    byte_item_t    head_item;
    logic          push;
    logic          pop;

    // front: accepts bytes, flags header bytes
    lspp_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    // decoupling queue; depth must be a power of two
    lspp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    // back: packet state machine and result register
    lspp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_item    (head_item),
        .q_status     (q_status),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .sample_index (sample_index),
        .distance_mm  (distance_mm),
        .start_angle  (start_angle),
        .end_angle    (end_angle),
        .packet_type  (packet_type),
        .last         (last),
        .checksum_ok  (checksum_ok)
    );

endmodule
`default_nettype wire
